// ===== rtl/core/wscfm_pkg.sv =====
package wscfm_pkg;

   // default window size in bytes
   localparam int WINDOW_BYTES_DEFAULT = 4096;

   // cursor width and the extra step taken by a call
   localparam int CURSOR_W   = 32;
   localparam int CALL_EXTRA = 4;

   // request codes
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_START = 2'd1;
   localparam logic [1:0] REQ_ELEM  = 2'd2;

   // element codes
   localparam logic [1:0] ELEM_EXACT = 2'd0;
   localparam logic [1:0] ELEM_WILD  = 2'd1;
   localparam logic [1:0] ELEM_CALL  = 2'd2;

   // input item
   typedef struct packed {
      logic [1:0]  req_type;
      logic [11:0] address;
      logic [7:0]  load_byte;
      logic [1:0]  elem_kind;
      logic [7:0]  elem_byte;
      logic        elem_last;
   } req_item_type;

   // result item
   typedef struct packed {
      logic matched;
      logic out_of_window;
   } rsp_item_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_CALL,
      ST_ADD,
      ST_RESP
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_wr;
      logic       start_set;
      logic       elem_latch;
      logic       wild_adv;
      logic       mark_out;
      logic       rd_en;
      logic [1:0] rd_off;
      logic       cmp_apply;
      logic       disp_shift;
      logic       call_add;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic failed;
      logic byte_ok;
      logic call_ok;
   } dp_status_type;

endpackage

// ===== rtl/core/wildcard_signature_call_follow_match_top.sv =====
// Channel   Ports                         Handshake
// input     start, busy, req_item         taken when start high and busy low
// result    rsp_valid, rsp_item           one-cycle strobe, no back-pressure
//
// Load, start and wildcard items are handled in the idle state; an exact byte
// takes a registered window read, then the compare; a call takes four byte
// reads through the single window port, then the cursor add.
// An element marked last then passes through a state in which the result is strobed.
// Reset is synchronous; the window store is not cleared and reads as unknown
// until loaded. The receiver cannot stall: a result is lost if not taken.
module wildcard_signature_call_follow_match_top #(
   parameter int WINDOW_BYTES = wscfm_pkg::WINDOW_BYTES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  wscfm_pkg::req_item_type  req_item,
   output logic                     rsp_valid,
   output wscfm_pkg::rsp_item_type  rsp_item
);

   wscfm_pkg::ctrl_cmd_type  cmd;
   wscfm_pkg::dp_status_type status;

   wscfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   wscfm_dp #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/core/wscfm_ctrl.sv =====
module wscfm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  wscfm_pkg::req_item_type   req_item,
   input  wscfm_pkg::dp_status_type  status,
   output wscfm_pkg::ctrl_cmd_type   cmd,
   output logic                      busy,
   output logic                      rsp_valid
);

   wscfm_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       last_ff, last_in;
   logic       accept;
   logic       is_elem;
   logic       active_exact;
   logic       active_call;
   logic       after_elem_last;

   // accept decode
   assign accept       = start && (state_ff == wscfm_pkg::ST_IDLE);
   assign is_elem      = accept && (req_item.req_type == wscfm_pkg::REQ_ELEM);
   assign active_exact = is_elem && !status.failed
                         && (req_item.elem_kind == wscfm_pkg::ELEM_EXACT);
   assign active_call  = is_elem && !status.failed
                         && (req_item.elem_kind == wscfm_pkg::ELEM_CALL);

   assign after_elem_last = (state_ff == wscfm_pkg::ST_IDLE) ? req_item.elem_last : last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      case (state_ff)
         wscfm_pkg::ST_IDLE: begin
            if (is_elem) begin
               last_in = req_item.elem_last;
               cnt_in  = 2'd1;
               if (active_exact && status.byte_ok) begin
                  state_in = wscfm_pkg::ST_BYTE;
               end else if (active_call && status.call_ok) begin
                  state_in = wscfm_pkg::ST_CALL;
               end else if (req_item.elem_last) begin
                  state_in = wscfm_pkg::ST_RESP;
               end
            end
         end
         wscfm_pkg::ST_BYTE: begin
            state_in = after_elem_last ? wscfm_pkg::ST_RESP : wscfm_pkg::ST_IDLE;
         end
         wscfm_pkg::ST_CALL: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = wscfm_pkg::ST_ADD;
            end
         end
         wscfm_pkg::ST_ADD: begin
            state_in = after_elem_last ? wscfm_pkg::ST_RESP : wscfm_pkg::ST_IDLE;
         end
         wscfm_pkg::ST_RESP: begin
            state_in = wscfm_pkg::ST_IDLE;
         end
         default: begin
            state_in = wscfm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      rsp_valid = 1'b0;
      busy      = (state_ff != wscfm_pkg::ST_IDLE);
      case (state_ff)
         wscfm_pkg::ST_IDLE: begin
            cmd.load_wr    = accept && (req_item.req_type == wscfm_pkg::REQ_LOAD);
            cmd.start_set  = accept && (req_item.req_type == wscfm_pkg::REQ_START);
            cmd.elem_latch = is_elem;
            cmd.wild_adv   = is_elem && !status.failed
                             && (req_item.elem_kind == wscfm_pkg::ELEM_WILD);
            cmd.mark_out   = (active_exact && !status.byte_ok)
                             || (active_call && !status.call_ok);
            cmd.rd_en      = (active_exact && status.byte_ok)
                             || (active_call && status.call_ok);
            cmd.rd_off     = 2'd0;
         end
         wscfm_pkg::ST_BYTE: begin
            cmd.cmp_apply = 1'b1;
         end
         wscfm_pkg::ST_CALL: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_off     = cnt_ff;
            cmd.disp_shift = 1'b1;
         end
         wscfm_pkg::ST_ADD: begin
            cmd.call_add = 1'b1;
         end
         wscfm_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wscfm_pkg::ST_IDLE;
         cnt_ff   <= 2'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ===== rtl/core/wscfm_dp.sv =====
module wscfm_dp #(
   parameter int WINDOW_BYTES = wscfm_pkg::WINDOW_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wscfm_pkg::req_item_type   req_item,
   input  wscfm_pkg::ctrl_cmd_type   cmd,
   output wscfm_pkg::dp_status_type  status,
   output wscfm_pkg::rsp_item_type   rsp_item
);

   localparam int IDX_W = $clog2(WINDOW_BYTES);
   localparam int CW    = wscfm_pkg::CURSOR_W;
   localparam logic [CW-1:0] WIN_SIZE  = CW'(WINDOW_BYTES);
   localparam logic [CW-1:0] CALL_LAST = CW'(WINDOW_BYTES - 4);
   localparam logic [CW-1:0] CALL_STEP = CW'(wscfm_pkg::CALL_EXTRA);

   logic [7:0] window_mem [WINDOW_BYTES];

   logic [CW-1:0] cursor_ff, cursor_in;
   logic          failed_ff, failed_in;
   logic          left_ff, left_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    elem_byte_ff;
   logic [23:0]   disp_ff;
   logic [CW-1:0] load_addr;
   logic [IDX_W-1:0] rd_idx;

   assign load_addr = CW'(req_item.address);
   assign rd_idx    = cursor_ff[IDX_W-1:0] + IDX_W'(cmd.rd_off);

   // window store: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.load_wr && (load_addr < WIN_SIZE)) begin
         window_mem[load_addr[IDX_W-1:0]] <= req_item.load_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= window_mem[rd_idx];
      end
   end

   // element byte and displacement gathering
   always_ff @(posedge clock) begin
      if (cmd.elem_latch) begin
         elem_byte_ff <= req_item.elem_byte;
      end
      if (cmd.disp_shift) begin
         disp_ff <= {rd_data_ff, disp_ff[23:8]};
      end
   end

   // cursor and flags
   always_comb begin
      cursor_in = cursor_ff;
      failed_in = failed_ff;
      left_in   = left_ff;
      if (cmd.start_set) begin
         cursor_in = load_addr;
         failed_in = 1'b0;
         left_in   = 1'b0;
      end
      if (cmd.wild_adv) begin
         cursor_in = cursor_ff + CW'(1);
      end
      if (cmd.mark_out) begin
         failed_in = 1'b1;
         left_in   = 1'b1;
      end
      if (cmd.cmp_apply) begin
         if (rd_data_ff != elem_byte_ff) begin
            failed_in = 1'b1;
         end else begin
            cursor_in = cursor_ff + CW'(1);
         end
      end
      if (cmd.call_add) begin
         cursor_in = cursor_ff + {rd_data_ff, disp_ff} + CALL_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         failed_ff <= 1'b0;
         left_ff   <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         failed_ff <= failed_in;
         left_ff   <= left_in;
      end
   end

   // status and result
   assign status.failed  = failed_ff;
   assign status.byte_ok = (cursor_ff < WIN_SIZE);
   assign status.call_ok = (cursor_ff <= CALL_LAST);

   assign rsp_item.matched       = !failed_ff;
   assign rsp_item.out_of_window = left_ff;

endmodule

// ===== tb/wscfm_verdict_checker.sv =====
`timescale 1ns / 1ps

module wscfm_verdict_checker
   import wscfm_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   output int           fail_count,
   output int           verdicts_pending,
   output int           verdicts_seen,
   output int           hits_seen,
   output int           outside_seen
);

   // own picture of the window and of the walk through it
   logic [7:0]          win_mem [WINDOW_BYTES];
   logic [CURSOR_W-1:0] scan_cursor;
   logic                scan_failed;
   logic                scan_outside;
   rsp_item_type        expected_verdicts [$];

   int n_fail    = 0;
   int n_pending = 0;
   int n_seen    = 0;
   int n_hits    = 0;
   int n_outside = 0;

   assign fail_count       = n_fail;
   assign verdicts_pending = n_pending;
   assign verdicts_seen    = n_seen;
   assign hits_seen        = n_hits;
   assign outside_seen     = n_outside;

   // advance the walk by one accepted item; queue a verdict on the last element
   task automatic apply_request(input req_item_type it);
      logic [31:0]  disp;
      rsp_item_type verdict;
      case (it.req_type)
         REQ_LOAD: begin
            if (it.address < WINDOW_BYTES) win_mem[it.address] = it.load_byte;
         end
         REQ_START: begin
            scan_cursor  = CURSOR_W'(it.address);
            scan_failed  = 1'b0;
            scan_outside = 1'b0;
         end
         REQ_ELEM: begin
            // once failed, further elements leave everything as it is
            if (!scan_failed) begin
               case (it.elem_kind)
                  ELEM_EXACT: begin
                     if (scan_cursor < WINDOW_BYTES) begin
                        if (win_mem[scan_cursor] != it.elem_byte) scan_failed = 1'b1;
                        else scan_cursor = scan_cursor + 1;
                     end else begin
                        scan_failed  = 1'b1;
                        scan_outside = 1'b1;
                     end
                  end
                  ELEM_WILD: scan_cursor = scan_cursor + 1;
                  ELEM_CALL: begin
                     // all four displacement bytes must lie in the window
                     if (scan_cursor < WINDOW_BYTES && WINDOW_BYTES - scan_cursor >= 4) begin
                        disp = {win_mem[scan_cursor + 3], win_mem[scan_cursor + 2],
                                win_mem[scan_cursor + 1], win_mem[scan_cursor]};
                        scan_cursor = scan_cursor + disp + CALL_EXTRA;
                     end else begin
                        scan_failed  = 1'b1;
                        scan_outside = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            if (it.elem_last) begin
               verdict.matched       = !scan_failed;
               verdict.out_of_window = scan_outside;
               expected_verdicts.push_back(verdict);
            end
         end
         default: ;
      endcase
   endtask

   // compare a strobed verdict against the oldest one waiting
   task automatic check_verdict(input rsp_item_type got);
      rsp_item_type want;
      n_seen++;
      if (got.matched === 1'b1) n_hits++;
      if (got.out_of_window === 1'b1) n_outside++;
      if (expected_verdicts.size() == 0) begin
         $error("verdict strobed with none expected: matched %0b, out_of_window %0b",
                got.matched, got.out_of_window);
         n_fail++;
      end else begin
         want = expected_verdicts.pop_front();
         if (got.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, got.matched);
            n_fail++;
         end
         if (got.out_of_window !== want.out_of_window) begin
            $error("out_of_window: expected %0b, got %0b",
                   want.out_of_window, got.out_of_window);
            n_fail++;
         end
      end
   endtask

   // watch both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         scan_cursor  = '0;
         scan_failed  = 1'b0;
         scan_outside = 1'b0;
         expected_verdicts.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            check_verdict(rsp_item);
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid: expected 0 or 1, got %b", rsp_valid);
            n_fail++;
         end
         if (start === 1'b1 && busy === 1'b0) apply_request(req_item);
      end
      n_pending = expected_verdicts.size();
   end

endmodule

// ===== tb/tb_wildcard_signature_call_follow_match_top.sv =====
`timescale 1ns / 1ps

module tb_wildcard_signature_call_follow_match_top;
   import wscfm_pkg::*;

   localparam int         WIN         = WINDOW_BYTES_DEFAULT;
   localparam int         ITEM_TARGET = 1350;
   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam logic [1:0] ELEM_SPARE  = 2'd3;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   int fail_count;
   int verdicts_pending;
   int verdicts_seen;
   int hits_seen;
   int outside_seen;

   int cycle_count = 0;
   int items_sent  = 0;
   int sig_count   = 0;
   int idle_pct    = 12;

   // stimulus-side image of the window and walk, so no unloaded byte is ever read
   logic [7:0]  img_val [WIN];
   bit          img_set [WIN];
   logic [31:0] walk_cur  = '0;
   bit          walk_dead = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wildcard_signature_call_follow_match_top #(
      .WINDOW_BYTES (WIN)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   wscfm_verdict_checker #(
      .WINDOW_BYTES (WIN)
   ) verdict_chk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_item         (rsp_item),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending),
      .verdicts_seen    (verdicts_seen),
      .hits_seen        (hits_seen),
      .outside_seen     (outside_seen)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // every field random; callers overwrite the ones that matter
   function automatic req_item_type rand_item();
      req_item_type it;
      it.req_type  = 2'($urandom_range(3));
      it.address   = 12'($urandom);
      it.load_byte = 8'($urandom);
      it.elem_kind = 2'($urandom_range(3));
      it.elem_byte = 8'($urandom);
      it.elem_last = 1'($urandom_range(1));
      return it;
   endfunction

   // drive one item, with an occasional gap first, and wait until it is taken
   task automatic issue(input req_item_type it);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      if (it.req_type != REQ_SPARE) items_sent++;
   endtask

   // hold off until every queued verdict has come back
   task automatic await_drain();
      start <= 1'b0;
      @(negedge clock);
      while (verdicts_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load_byte_at(input logic [11:0] at, input logic [7:0] val);
      req_item_type it;
      it           = rand_item();
      it.req_type  = REQ_LOAD;
      it.address   = at;
      it.load_byte = val;
      img_val[at]  = val;
      img_set[at]  = 1'b1;
      issue(it);
   endtask

   task automatic start_at(input logic [11:0] at);
      req_item_type it;
      it          = rand_item();
      it.req_type = REQ_START;
      it.address  = at;
      walk_cur    = 32'(at);
      walk_dead   = 1'b0;
      issue(it);
   endtask

   // send one element and move the stimulus image of the walk along
   task automatic send_elem(input logic [1:0] kind, input logic [7:0] val, input bit last);
      req_item_type it;
      it           = rand_item();
      it.req_type  = REQ_ELEM;
      it.elem_kind = kind;
      it.elem_byte = val;
      it.elem_last = last;
      if (!walk_dead) begin
         case (kind)
            ELEM_EXACT: begin
               if (walk_cur >= WIN || img_val[walk_cur] != val) walk_dead = 1'b1;
               else walk_cur = walk_cur + 1;
            end
            ELEM_WILD: walk_cur = walk_cur + 1;
            ELEM_CALL: begin
               if (walk_cur > WIN - 4) walk_dead = 1'b1;
               else walk_cur = walk_cur + 32'd4 + {img_val[walk_cur + 3], img_val[walk_cur + 2],
                                                   img_val[walk_cur + 1], img_val[walk_cur]};
            end
            default: ;
         endcase
      end
      issue(it);
   endtask

   // write a call displacement at the cursor, mostly landing back in the window
   task automatic plant_call(input logic [31:0] at);
      logic [31:0] target;
      logic [31:0] disp;
      int          r;
      r = $urandom_range(99);
      if (r < 55)      target = at + 4 + $urandom_range(0, 40);
      else if (r < 75) target = $urandom_range(0, WIN - 1);
      else if (r < 85) target = $urandom_range(WIN - 4, WIN - 1);
      else if (r < 93) target = -$urandom_range(1, 64);
      else             target = $urandom;
      disp = target - at - 4;
      for (int k = 0; k < 4; k++) load_byte_at(12'(at + k), disp[8 * k +: 8]);
   endtask

   // choose an element that never reads an unloaded byte
   task automatic pick_elem(input bit last);
      logic [7:0] val;
      int         r;
      r   = $urandom_range(99);
      val = 8'($urandom);
      if (walk_dead) begin
         send_elem(2'($urandom_range(3)), val, last);
      end else if (r < 45) begin
         if (walk_cur < WIN) begin
            if (!img_set[walk_cur]) load_byte_at(walk_cur[11:0], 8'($urandom));
            val = img_val[walk_cur];
            if ($urandom_range(99) < 12) val = val ^ 8'($urandom_range(1, 255));
         end
         send_elem(ELEM_EXACT, val, last);
      end else if (r < 70) begin
         if (walk_cur <= WIN - 4 &&
             (!(img_set[walk_cur] && img_set[walk_cur + 1] && img_set[walk_cur + 2] &&
                img_set[walk_cur + 3]) || $urandom_range(99) < 35))
            plant_call(walk_cur);
         send_elem(ELEM_CALL, val, last);
      end else if (r < 95) begin
         send_elem(ELEM_WILD, val, last);
      end else begin
         send_elem(ELEM_SPARE, val, last);
      end
   endtask

   // one signature: a few loose loads, usually a start, then its elements
   task automatic run_signature();
      int           n_elems;
      logic [11:0]  origin;
      req_item_type spare;
      n_elems = $urandom_range(1, 10);
      repeat ($urandom_range(0, 3)) load_byte_at(12'($urandom), 8'($urandom));
      case ($urandom_range(9))
         0:       origin = 12'($urandom_range(WIN - 16, WIN - 1));
         1:       origin = 12'($urandom_range(0, 15));
         default: origin = 12'($urandom);
      endcase
      // now and then carry on from wherever the previous walk stopped
      if ($urandom_range(99) < 92) start_at(origin);
      for (int i = 0; i < n_elems; i++) begin
         if ($urandom_range(99) < 2) begin
            spare          = rand_item();
            spare.req_type = REQ_SPARE;
            issue(spare);
         end
         // a few signatures are left without their last element
         pick_elem(i == n_elems - 1 && $urandom_range(99) < 95);
      end
      // stray elements after the last one
      if ($urandom_range(99) < 6) repeat ($urandom_range(1, 3)) pick_elem(1'($urandom_range(1)));
   endtask

   initial begin
      req_item_type spare;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // no start yet: walk from cursor zero, then keep going past the last element
      load_byte_at(12'd0, 8'hA5);
      load_byte_at(12'd1, 8'h3C);
      send_elem(ELEM_EXACT, 8'hA5, 1'b1);
      send_elem(ELEM_EXACT, 8'h3C, 1'b1);

      // byte compare running off the top of the window
      load_byte_at(12'hFFF, 8'hFF);
      start_at(12'hFFF);
      send_elem(ELEM_EXACT, 8'hFF, 1'b0);
      send_elem(ELEM_EXACT, 8'h00, 1'b1);

      // call in the top four bytes, displacement wrapping back to byte zero
      load_byte_at(12'hFFC, 8'h00);
      load_byte_at(12'hFFD, 8'hF0);
      load_byte_at(12'hFFE, 8'hFF);
      load_byte_at(12'hFFF, 8'hFF);
      start_at(12'hFFC);
      send_elem(ELEM_CALL, 8'h00, 1'b0);
      send_elem(ELEM_EXACT, 8'hA5, 1'b1);

      // call one byte too high to fit its displacement
      start_at(12'hFFD);
      send_elem(ELEM_CALL, 8'hFF, 1'b1);

      // negative displacement passing below zero; the wildcard is not checked
      load_byte_at(12'd16, 8'hD8);
      load_byte_at(12'd17, 8'hFF);
      load_byte_at(12'd18, 8'hFF);
      load_byte_at(12'd19, 8'hFF);
      start_at(12'd16);
      send_elem(ELEM_CALL, 8'h00, 1'b0);
      send_elem(ELEM_WILD, 8'h00, 1'b0);
      send_elem(ELEM_EXACT, 8'h5A, 1'b1);

      // mismatch, then the unused element kind closing the signature
      start_at(12'd0);
      send_elem(ELEM_EXACT, 8'h5A, 1'b0);
      send_elem(ELEM_SPARE, 8'h00, 1'b1);

      // ignored request type
      spare          = rand_item();
      spare.req_type = REQ_SPARE;
      issue(spare);

      // random signatures, with a stretch sent without gaps and a full drain every twentieth signature
      while (items_sent < ITEM_TARGET) begin
         idle_pct = (items_sent > 500 && items_sent < 800) ? 0 : 12;
         run_signature();
         sig_count++;
         if (sig_count % 20 == 0) await_drain();
      end

      await_drain();
      repeat (20) @(posedge clock);
      @(negedge clock);

      $display("Sent %0d items in %0d random signatures plus directed cases",
               items_sent, sig_count);
      $display("Checked %0d verdicts: %0d matched, %0d left the window",
               verdicts_seen, hits_seen, outside_seen);
      if (fail_count == 0 && verdicts_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/wscfm_pkg.sv
rtl/core/wscfm_ctrl.sv
rtl/core/wscfm_dp.sv
rtl/core/wildcard_signature_call_follow_match_top.sv
tb/wscfm_verdict_checker.sv
tb/tb_wildcard_signature_call_follow_match_top.sv
